>>> rtl/sedt_pkg.sv
// sedt_pkg: shared types and constants of the sobel edge threshold unit
// payload structs, window type, register indexes and reset values
// no dependencies
package sedt_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int MIN_DIM   = 3;

    // gradient arithmetic widths
    localparam int SUM_W    = 10;   // weighted column or row sum, max 1020
    localparam int SQ_W     = 2 * SUM_W;
    localparam int MAG_W    = SQ_W + 1;
    localparam int THR_SQ_W = 2 * CFG_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH    = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT   = 11'd480;
    localparam logic [CFG_W-1:0] RST_EDGE_THRESHOLD = 11'd255;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pix_in;

    typedef struct packed {
        logic               edge_res;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic               last_of_frame;
    } t_edge_out;

    // per-pixel position info carried alongside the data
    typedef struct packed {
        logic               has_res;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic               last;
    } t_res_meta;

    // 3x3 window, entry r*3+c, column 2 is the newest
    typedef logic [8:0][PIX_W-1:0] t_win;

endpackage

>>> rtl/sobel_edge_threshold_unit.sv
// sobel_edge_threshold_unit: streaming 3x3 sobel edge detector with threshold
// top level: configuration registers, pipeline wiring, assertions
// depends on sedt_pkg, sedt_pos_ctrl, sedt_line_win, sedt_grad, sedt_out_skid
//
// usage
// - pixel channel (i_in_valid / o_in_ready / i_in_data): 8-bit pixels in raster
//   order, frame_start marks pixel (0,0); without it rows and frames wrap
//   on the configured width and height
// - result channel (o_res_valid / i_res_ready / o_res_data): one transaction per
//   pixel whose 3x3 window lies fully in the frame, tagged with the window's
//   top-left column and row, last_of_frame on the bottom-right window
// - config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   always ready; index 0 is frame width, index 1 is frame height, index 2 is edge threshold;
//   write only while no pixel is in flight
// - throughput: one pixel per clock while the skid entry is empty, set by the line
//   store read/write per pixel; results leave through the output register
// - stall: the output register plus one skid entry absorb a stalled receiver;
//   the whole pipeline then freezes and o_in_ready drops
// - reset: width 640, height 480, threshold 255, counters and window cleared;
//   line stores are not cleared and hold stale data until rows are written
module sobel_edge_threshold_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  sedt_pkg::t_pix_in              i_in_data,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output sedt_pkg::t_edge_out            o_res_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sedt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sedt_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    // configuration registers
    logic [sedt_pkg::CFG_W-1:0] r_frame_width;
    logic [sedt_pkg::CFG_W-1:0] r_frame_height;
    logic [sedt_pkg::CFG_W-1:0] r_edge_threshold;

    // pipeline advance, low only while the skid entry is occupied
    logic                w_en;
    logic                w_in_accept;
    logic [CW-1:0]       w_idx;
    sedt_pkg::t_res_meta w_meta;

    sedt_pkg::t_win      w_win;
    logic                w_s2_valid;
    sedt_pkg::t_res_meta w_s2_meta;

    logic                w_s4_valid;
    sedt_pkg::t_edge_out w_s4_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_en;
    assign w_in_accept = i_in_valid && w_en;

    // config write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= sedt_pkg::RST_FRAME_WIDTH;
            r_frame_height   <= sedt_pkg::RST_FRAME_HEIGHT;
            r_edge_threshold <= sedt_pkg::RST_EDGE_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sedt_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                end
                sedt_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                end
                sedt_pkg::CFG_EDGE_THRESHOLD: begin
                    r_edge_threshold <= i_cfg_data;
                end
                default: begin
                    // unused index, write is dropped
                end
            endcase
        end
    end

    // position counters step on each accepted pixel
    sedt_pos_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_in_accept),
        .i_frame_start  (i_in_data.frame_start),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_idx          (w_idx),
        .o_meta         (w_meta)
    );

    // stage 1: line store read, stage 2: window shift and line store update
    sedt_line_win #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_accept (w_in_accept),
        .i_idx    (w_idx),
        .i_pixel  (i_in_data.pixel),
        .i_meta   (w_meta),
        .o_win    (w_win),
        .o_valid  (w_s2_valid),
        .o_meta   (w_s2_meta)
    );

    // stages 3 and 4: gradients then squares, compare ahead of the output register
    sedt_grad u_grad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_s2_valid),
        .i_win       (w_win),
        .i_meta      (w_s2_meta),
        .i_threshold (r_edge_threshold),
        .o_valid     (w_s4_valid),
        .o_res       (w_s4_res)
    );

    sedt_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && w_s4_valid),
        .i_data  (w_s4_res),
        .o_ready (w_en),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_data  (o_res_data)
    );

    // a frozen pipeline means both output entries are full
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_res_valid)
        else $error("pipeline stalled with empty output register");

    // the first pixel of a frame never completes a window
    a_start_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_in_data.frame_start) |-> !w_meta.has_res)
        else $error("result flagged for frame start pixel");

    // back-to-back pixels use different line store entries unless a frame restarts
    a_idx_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && $past(w_in_accept) && $past(i_rst_n)
            && !i_in_data.frame_start) |-> (w_idx != $past(w_idx)))
        else $error("consecutive pixels map to the same line store entry");

endmodule

>>> rtl/sedt_pos_ctrl.sv
// sedt_pos_ctrl: raster column and row counters with dimension clamping
// produces the line store index and result position of each pixel
// depends on sedt_pkg
module sedt_pos_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_frame_start,
    input  logic [sedt_pkg::CFG_W-1:0] i_frame_width,
    input  logic [sedt_pkg::CFG_W-1:0] i_frame_height,
    output logic [CW-1:0]              o_idx,
    output sedt_pkg::t_res_meta        o_meta
);

    localparam int XW = (CW + 1 > sedt_pkg::CFG_W) ? CW + 1 : sedt_pkg::CFG_W;
    localparam int YW = (RW + 1 > sedt_pkg::CFG_W) ? RW + 1 : sedt_pkg::CFG_W;

    logic [CW-1:0] r_col, n_col, w_col, w_last_col;
    logic [RW-1:0] r_row, n_row, w_row, w_last_row;
    logic [XW-1:0] w_fw_x;
    logic [YW-1:0] w_fh_x;
    logic          w_is_last_col, w_is_last_row;

    always_comb begin
        w_col  = i_frame_start ? '0 : r_col;
        w_row  = i_frame_start ? '0 : r_row;
        w_fw_x = XW'(i_frame_width);
        w_fh_x = YW'(i_frame_height);

        // last position index of each dimension after clamping
        if (w_fw_x < XW'(sedt_pkg::MIN_DIM)) begin
            w_last_col = CW'(sedt_pkg::MIN_DIM - 1);
        end else if (w_fw_x > XW'(MAX_WIDTH)) begin
            w_last_col = CW'(MAX_WIDTH - 1);
        end else begin
            w_last_col = CW'(w_fw_x - XW'(1));
        end
        if (w_fh_x < YW'(sedt_pkg::MIN_DIM)) begin
            w_last_row = RW'(sedt_pkg::MIN_DIM - 1);
        end else if (w_fh_x > YW'(MAX_HEIGHT)) begin
            w_last_row = RW'(MAX_HEIGHT - 1);
        end else begin
            w_last_row = RW'(w_fh_x - YW'(1));
        end

        // a counter past a shrunk dimension counts as the last position
        w_is_last_col = (w_col >= w_last_col);
        w_is_last_row = (w_row >= w_last_row);

        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (w_is_last_col) begin
                n_col = '0;
                n_row = w_is_last_row ? '0 : w_row + RW'(1);
            end else begin
                n_col = w_col + CW'(1);
                n_row = w_row;
            end
        end

        o_idx           = w_col;
        o_meta.has_res  = (w_col >= CW'(2)) && (w_row >= RW'(2));
        o_meta.out_col  = sedt_pkg::COORD_W'(w_col - CW'(2));
        o_meta.out_row  = sedt_pkg::COORD_W'(w_row - RW'(2));
        o_meta.last     = w_is_last_col && w_is_last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

>>> rtl/sedt_line_win.sv
// sedt_line_win: two line stores and the 3x3 window register
// line store read is registered, with a forward for back-to-back same index
// depends on sedt_pkg
module sedt_line_win #(
    parameter int MAX_WIDTH = 1024,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_accept,
    input  logic [CW-1:0]              i_idx,
    input  logic [sedt_pkg::PIX_W-1:0] i_pixel,
    input  sedt_pkg::t_res_meta        i_meta,
    output sedt_pkg::t_win             o_win,
    output logic                       o_valid,
    output sedt_pkg::t_res_meta        o_meta
);

    logic [sedt_pkg::PIX_W-1:0] r_mem_a [MAX_WIDTH];   // row above
    logic [sedt_pkg::PIX_W-1:0] r_mem_b [MAX_WIDTH];   // two rows above

    logic                       r_s1_valid;
    logic [CW-1:0]              r_s1_idx;
    logic [sedt_pkg::PIX_W-1:0] r_s1_pix;
    sedt_pkg::t_res_meta        r_s1_meta;

    logic [sedt_pkg::PIX_W-1:0] r_rd_a, r_rd_b;
    logic                       r_byp;
    logic [sedt_pkg::PIX_W-1:0] r_byp_a, r_byp_b;
    logic [sedt_pkg::PIX_W-1:0] w_col_a, w_col_b;
    logic                       w_hit;

    sedt_pkg::t_win             r_win, n_win;
    logic                       r_s2_valid;
    sedt_pkg::t_res_meta        r_s2_meta;

    // stage 1 entry written at this edge while the next one reads the same index
    assign w_hit   = r_s1_valid && (r_s1_idx == i_idx);
    assign w_col_a = r_byp ? r_byp_a : r_rd_a;
    assign w_col_b = r_byp ? r_byp_b : r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_s1_valid) begin
                r_mem_a[r_s1_idx] <= r_s1_pix;
                r_mem_b[r_s1_idx] <= w_col_a;
            end
            r_rd_a <= r_mem_a[i_idx];
            r_rd_b <= r_mem_b[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byp_a   <= r_s1_pix;
            r_byp_b   <= w_col_a;
            r_s1_idx  <= i_idx;
            r_s1_pix  <= i_pixel;
            r_s1_meta <= i_meta;
            r_s2_meta <= r_s1_meta;
        end
    end

    always_comb begin
        n_win = r_win;
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3 + 1];
            n_win[r*3 + 1] = r_win[r*3 + 2];
        end
        n_win[2] = w_col_b;
        n_win[5] = w_col_a;
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
            r_s2_valid <= 1'b0;
            r_win      <= '0;
        end else if (i_en) begin
            r_s1_valid <= i_accept;
            r_byp      <= w_hit;
            r_s2_valid <= r_s1_valid && r_s1_meta.has_res;
            if (r_s1_valid) begin
                r_win <= n_win;
            end
        end
    end

    assign o_win   = r_win;
    assign o_valid = r_s2_valid;
    assign o_meta  = r_s2_meta;

endmodule

>>> rtl/sedt_grad.sv
// sedt_grad: sobel gradients, squared magnitude and threshold compare
// two register stages: absolute gradients, then squares
// depends on sedt_pkg
module sedt_grad (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  sedt_pkg::t_win             i_win,
    input  sedt_pkg::t_res_meta        i_meta,
    input  logic [sedt_pkg::CFG_W-1:0] i_threshold,
    output logic                       o_valid,
    output sedt_pkg::t_edge_out        o_res
);

    localparam int SW = sedt_pkg::SUM_W;

    logic [SW-1:0] w_gx_pos, w_gx_neg, w_gy_pos, w_gy_neg;
    logic [SW-1:0] w_agx, w_agy;

    logic                           r_s3_valid, r_s4_valid;
    logic [SW-1:0]                  r_agx, r_agy;
    sedt_pkg::t_res_meta            r_s3_meta, r_s4_meta;
    logic [sedt_pkg::SQ_W-1:0]      w_sqx, w_sqy, r_sqx, r_sqy;
    logic [sedt_pkg::THR_SQ_W-1:0]  w_thr_sq, r_thr_sq;
    logic [sedt_pkg::MAG_W-1:0]     w_mag2;

    // x kernel: left column weighted 1 2 1 minus right column
    // y kernel: top row weighted 1 2 1 minus bottom row
    always_comb begin
        w_gx_pos = SW'(i_win[0]) + {1'b0, i_win[3], 1'b0} + SW'(i_win[6]);
        w_gx_neg = SW'(i_win[2]) + {1'b0, i_win[5], 1'b0} + SW'(i_win[8]);
        w_gy_pos = SW'(i_win[0]) + {1'b0, i_win[1], 1'b0} + SW'(i_win[2]);
        w_gy_neg = SW'(i_win[6]) + {1'b0, i_win[7], 1'b0} + SW'(i_win[8]);
        w_agx = (w_gx_pos >= w_gx_neg) ? w_gx_pos - w_gx_neg : w_gx_neg - w_gx_pos;
        w_agy = (w_gy_pos >= w_gy_neg) ? w_gy_pos - w_gy_neg : w_gy_neg - w_gy_pos;
    end

    assign w_sqx    = sedt_pkg::SQ_W'(r_agx) * sedt_pkg::SQ_W'(r_agx);
    assign w_sqy    = sedt_pkg::SQ_W'(r_agy) * sedt_pkg::SQ_W'(r_agy);
    assign w_thr_sq = sedt_pkg::THR_SQ_W'(i_threshold) * sedt_pkg::THR_SQ_W'(i_threshold);
    assign w_mag2   = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        r_thr_sq <= w_thr_sq;
        if (i_en) begin
            r_agx     <= w_agx;
            r_agy     <= w_agy;
            r_s3_meta <= i_meta;
            r_sqx     <= w_sqx;
            r_sqy     <= w_sqy;
            r_s4_meta <= r_s3_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= i_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_comb begin
        o_res.edge_res      = ({1'b0, w_mag2} > r_thr_sq);
        o_res.out_col       = r_s4_meta.out_col;
        o_res.out_row       = r_s4_meta.out_row;
        o_res.last_of_frame = r_s4_meta.last;
    end

    assign o_valid = r_s4_valid;

endmodule

>>> rtl/sedt_out_skid.sv
// sedt_out_skid: output register plus one skid entry
// pipeline advance is a registered signal, not the downstream ready
// depends on sedt_pkg
module sedt_out_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sedt_pkg::t_edge_out i_data,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output sedt_pkg::t_edge_out o_data
);

    logic                r_out_valid, n_out_valid;
    logic                r_skd_valid, n_skd_valid;
    sedt_pkg::t_edge_out r_out, n_out, r_skd, n_skd;
    logic                w_pop;

    assign w_pop = r_out_valid && i_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_skd_valid = r_skd_valid;
        n_out       = r_out;
        n_skd       = r_skd;
        if (r_skd_valid) begin
            if (w_pop) begin
                n_out       = r_skd;
                n_skd_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skd       = i_data;
                n_skd_valid = 1'b1;
            end
        end else if (w_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skd <= n_skd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_skd_valid <= n_skd_valid;
        end
    end

    assign o_ready = !r_skd_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> test/sobel_edge_threshold_unit_test.sv
// sobel_edge_threshold_unit_test: self-checking bench for the sobel edge threshold unit
// streams pixel frames under several register settings and handshake stall patterns
// depends on sedt_pkg and sobel_edge_threshold_unit
`timescale 1ns / 100ps

module sobel_edge_threshold_unit_test;

    localparam int          MAX_DIM       = 1024;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          RANDOM_PIXELS = 850;
    localparam int          TALL_ROWS     = 50;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    // index 3 is not a register, writes there must change nothing
    localparam logic [sedt_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // tracks raster position, line stores and window, predicts one result per full window
    class edge_scoreboard;
        bit [sedt_pkg::PIX_W-1:0]   row_above     [MAX_DIM];
        bit [sedt_pkg::PIX_W-1:0]   row_two_above [MAX_DIM];
        bit [sedt_pkg::PIX_W-1:0]   win [9];
        int unsigned                col_pos = 0;
        int unsigned                row_pos = 0;
        logic [sedt_pkg::CFG_W-1:0] width_reg     = sedt_pkg::RST_FRAME_WIDTH;
        logic [sedt_pkg::CFG_W-1:0] height_reg    = sedt_pkg::RST_FRAME_HEIGHT;
        logic [sedt_pkg::CFG_W-1:0] threshold_reg = sedt_pkg::RST_EDGE_THRESHOLD;
        sedt_pkg::t_edge_out        expected_edges [$];
        int unsigned                errors = 0;

        static function int unsigned clamp_dim(int unsigned raw);
            if (raw < sedt_pkg::MIN_DIM) return sedt_pkg::MIN_DIM;
            if (raw > MAX_DIM) return MAX_DIM;
            return raw;
        endfunction

        // returns 1 when the usable width grew, so the caller restarts the frame
        function bit write_register(logic [sedt_pkg::CFG_IDX_W-1:0] idx,
                                    logic [sedt_pkg::CFG_W-1:0] data);
            int unsigned old_width;
            old_width = clamp_dim(width_reg);
            case (idx)
                sedt_pkg::CFG_FRAME_WIDTH:    width_reg     = data;
                sedt_pkg::CFG_FRAME_HEIGHT:   height_reg    = data;
                sedt_pkg::CFG_EDGE_THRESHOLD: threshold_reg = data;
                default: ;
            endcase
            return clamp_dim(width_reg) > old_width;
        endfunction

        function void note_pixel(sedt_pkg::t_pix_in item);
            int unsigned         w, h, col, row, idx;
            int                  gx, gy, mag2, thr2, r;
            bit                  last_col, last_row;
            sedt_pkg::t_edge_out want;
            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            if (item.frame_start) begin
                col_pos = 0;
                row_pos = 0;
            end
            col = col_pos;
            row = row_pos;
            idx = (col < MAX_DIM) ? col : MAX_DIM - 1;
            // window moves one column left, new column from the two line stores and the pixel
            for (r = 0; r < 3; r++) begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = row_two_above[idx];
            win[5] = row_above[idx];
            win[8] = item.pixel;
            row_two_above[idx] = row_above[idx];
            row_above[idx]     = item.pixel;
            last_col = (col >= w - 1);
            last_row = (row >= h - 1);
            if (col >= 2 && row >= 2) begin
                gx = (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]))
                   - (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]));
                gy = (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]))
                   - (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]));
                mag2 = gx * gx + gy * gy;
                thr2 = int'(threshold_reg) * int'(threshold_reg);
                want.edge_res      = (mag2 > thr2);
                want.out_col       = sedt_pkg::COORD_W'(col - 2);
                want.out_row       = sedt_pkg::COORD_W'(row - 2);
                want.last_of_frame = last_col && last_row;
                expected_edges.push_back(want);
            end
            if (last_col) begin
                col_pos = 0;
                row_pos = last_row ? 0 : row + 1;
            end else begin
                col_pos = col + 1;
            end
        endfunction

        function void check_result(sedt_pkg::t_edge_out got);
            sedt_pkg::t_edge_out want;
            if (expected_edges.size() == 0) begin
                $error("result with none expected: col %0d row %0d", got.out_col, got.out_row);
                errors++;
                return;
            end
            want = expected_edges.pop_front();
            if (got.edge_res !== want.edge_res) begin
                $error("edge_res: expected %0d, got %0d", want.edge_res, got.edge_res);
                errors++;
            end
            if (got.out_col !== want.out_col) begin
                $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
                errors++;
            end
            if (got.out_row !== want.out_row) begin
                $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
                errors++;
            end
            if (got.last_of_frame !== want.last_of_frame) begin
                $error("last_of_frame: expected %0d, got %0d",
                       want.last_of_frame, got.last_of_frame);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_edges.size();
        endfunction
    endclass

    // clock, reset and block ports, all inputs known from time zero
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    sedt_pkg::t_pix_in              i_in_data   = '0;
    logic                           o_res_valid;
    logic                           i_res_ready = 1'b0;
    sedt_pkg::t_edge_out            o_res_data;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [sedt_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sedt_pkg::CFG_W-1:0]     i_cfg_data  = '0;

    edge_scoreboard             edge_sb;
    int unsigned                cycle_count        = 0;
    int unsigned                sender_gap_pct     = 0;
    int unsigned                receiver_stall_pct = 0;
    bit                         restart_pending    = 1'b0;
    logic [sedt_pkg::PIX_W-1:0] last_pixel         = '0;

    sobel_edge_threshold_unit #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res_data  (o_res_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // hard stop if the run hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: ready changes at the falling edge, stall rate set per phase
    initial begin
        forever begin
            @(negedge i_clk);
            i_res_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // every result transaction is checked at the rising edge it is taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) begin
            edge_sb.check_result(o_res_data);
        end
    end

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_gap_pct     = 60;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 60;
            end
            default: begin
                sender_gap_pct     = 34;
                receiver_stall_pct = 34;
            end
        endcase
    endtask

    // entered at a falling edge, leaves cfg valid high for a following write
    task automatic write_reg(input logic [sedt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sedt_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (edge_sb.write_register(idx, data)) begin
            restart_pending = 1'b1;
        end
        @(negedge i_clk);
    endtask

    // all three registers plus a write to the unused index, block must be idle
    task automatic configure(input logic [sedt_pkg::CFG_W-1:0] width, height, threshold);
        write_reg(sedt_pkg::CFG_FRAME_WIDTH, width);
        write_reg(sedt_pkg::CFG_FRAME_HEIGHT, height);
        write_reg(sedt_pkg::CFG_EDGE_THRESHOLD, threshold);
        write_reg(CFG_SPARE_INDEX, sedt_pkg::CFG_W'($urandom_range(2047)));
        i_cfg_valid <= 1'b0;
    endtask

    // one pixel transaction; valid stays high into the next call unless a gap is drawn
    task automatic push_pixel(input logic [sedt_pkg::PIX_W-1:0] pixel, input logic frame_start);
        sedt_pkg::t_pix_in item;
        // a wider row must start a new frame so no line store entry is read unwritten
        item.pixel       = pixel;
        item.frame_start = frame_start | restart_pending;
        restart_pending  = 1'b0;
        while ($urandom_range(99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        edge_sb.note_pixel(item);
        @(negedge i_clk);
    endtask

    // wait for every expected result, then let pixels with no result leave the pipeline
    task automatic drain();
        i_in_valid <= 1'b0;
        while (edge_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // mostly small frames so rows and frames wrap often; sometimes below minimum or wider
    function automatic logic [sedt_pkg::CFG_W-1:0] pick_dim(input int unsigned typical_max);
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0) return sedt_pkg::CFG_W'($urandom_range(2));
        if (roll == 1) return sedt_pkg::CFG_W'($urandom_range(typical_max + 1, 40));
        return sedt_pkg::CFG_W'($urandom_range(3, typical_max));
    endfunction

    // mix of noise, hard black/white steps and smooth ramps
    function automatic logic [sedt_pkg::PIX_W-1:0] next_pixel();
        case ($urandom_range(3))
            0:       last_pixel = sedt_pkg::PIX_W'($urandom_range(255));
            1:       last_pixel = $urandom_range(1) ? 8'hFF : 8'h00;
            default: last_pixel = last_pixel + sedt_pkg::PIX_W'($urandom_range(8)) - 8'd4;
        endcase
        return last_pixel;
    endfunction

    initial begin
        int unsigned phase, sent, burst, i;
        edge_sb = new();
        phase = 0;
        sent  = 0;

        // synchronous reset, released at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the smallest frame
        set_idle(IDLE_NONE);
        configure(11'd3, 11'd3, 11'd0);
        // flat frame: zero magnitude does not exceed a zero threshold
        for (i = 0; i < 9; i++) push_pixel(8'd0, i == 0);
        drain();
        // bright left column gives gx = 1020, just above the threshold;
        // frame wraps into the next one without frame_start
        configure(11'd3, 11'd3, 11'd1019);
        for (i = 0; i < 9; i++) push_pixel((i % 3 == 0) ? 8'hFF : 8'h00, 1'b0);
        drain();
        // magnitude equal to the threshold is not an edge
        configure(11'd3, 11'd3, 11'd1020);
        for (i = 0; i < 9; i++) push_pixel((i % 3 == 0) ? 8'hFF : 8'h00, i == 0);
        drain();

        // random frames; phases end mid-frame so new sizes often land on running counters
        while (sent < RANDOM_PIXELS) begin
            set_idle(t_idle_mode'(phase % 4));
            configure(pick_dim(12), pick_dim(8),
                      $urandom_range(1) ? sedt_pkg::CFG_W'($urandom_range(400))
                                        : sedt_pkg::CFG_W'($urandom_range(2047)));
            burst = $urandom_range(40, 160);
            // rare frame_start restarts a frame part way through
            repeat (burst) push_pixel(next_pixel(), $urandom_range(149) == 0);
            sent += burst;
            phase++;
            drain();
        end

        // tall frame on the narrowest rows, all height and threshold bits set,
        // threshold never exceeded
        set_idle(t_idle_mode'($urandom_range(3)));
        configure(11'd0, 11'd2047, 11'd2047);
        repeat (3 * TALL_ROWS) push_pixel(next_pixel(), 1'b0);
        drain();

        if (edge_sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
